// File: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define HDC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger
`define HDC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: rtl/hdc_pkg.sv
// Shared types and constants of the run-length decoder.
// No dependencies; used by hdc_decode_core and hdc_run_length_decoder.
package hdc_pkg;

  // Byte code boundaries
  localparam logic [7:0] RUN_BASE   = 8'd128;
  localparam logic [7:0] RUN_LAST   = 8'd190;
  localparam logic [7:0] LIT_BASE   = 8'd191;
  localparam logic [7:0] LIT_LAST   = 8'd254;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_RUN  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] literals_left;
    logic [6:0] pending_run_length;
    logic       error_flag;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [6:0] repeat_count;
    logic       bad_control;
    logic       error_seen;
    logic       last_out;
  } result_t;

  localparam dec_state_t STATE_RESET = '{
    mode: MODE_CTRL,
    literals_left: 7'd0,
    pending_run_length: 7'd0,
    error_flag: 1'b0
  };

endpackage

// File: rtl/hdc_decode_core.sv
// Combinational decode of one compressed byte against the decoder state.
// Depends on hdc_pkg for the state and result types and the code limits.
module hdc_decode_core (
  input  hdc_pkg::dec_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                end_of_stream,
  output hdc_pkg::dec_state_t st_next,
  output hdc_pkg::result_t    res0,
  output logic                res0_valid,
  output hdc_pkg::result_t    res1,
  output logic                res1_valid
);

  logic [6:0]       lit_off;
  logic [6:0]       run_off;
  logic             is_ctrl;
  logic             handle_ctrl;
  hdc_pkg::result_t ctrl_res;
  logic             ctrl_valid;

  assign lit_off = 7'(in_byte - hdc_pkg::LIT_BASE);
  assign run_off = 7'(in_byte - hdc_pkg::RUN_BASE);
  assign is_ctrl = (in_byte >= hdc_pkg::RUN_BASE) && (in_byte <= hdc_pkg::LIT_LAST);

  always_comb begin
    st_next     = st;
    res0        = '0;
    res0_valid  = 1'b0;
    res1        = '0;
    res1_valid  = 1'b0;
    handle_ctrl = 1'b0;
    ctrl_res    = '0;
    ctrl_valid  = 1'b0;

    // Data byte handling for the current mode
    case (st.mode)
      hdc_pkg::MODE_LIT: begin
        res0       = '{in_byte, 7'd1, 1'b0, st.error_flag, end_of_stream};
        res0_valid = 1'b1;
        st_next.literals_left = st.literals_left - 7'd1;
        if (st.literals_left == 7'd1) begin
          st_next.mode = hdc_pkg::MODE_CTRL;
        end
      end
      hdc_pkg::MODE_RUN: begin
        st_next.mode = hdc_pkg::MODE_CTRL;
        res0_valid   = 1'b1;
        if (is_ctrl) begin
          // control byte after a run announcement: run of spaces
          res0        = '{hdc_pkg::SPACE_BYTE, st.pending_run_length, 1'b0,
                          st.error_flag, 1'b0};
          handle_ctrl = 1'b1;
        end else begin
          res0 = '{in_byte, st.pending_run_length, 1'b0, st.error_flag, end_of_stream};
        end
        st_next.pending_run_length = 7'd0;
      end
      default: begin
        handle_ctrl = 1'b1;
      end
    endcase

    // Control byte handling
    if (handle_ctrl) begin
      if (in_byte inside {[hdc_pkg::LIT_BASE:hdc_pkg::LIT_LAST]}) begin
        if (end_of_stream) begin
          ctrl_res   = '{8'd0, 7'd0, 1'b0, st.error_flag, 1'b1};
          ctrl_valid = 1'b1;
        end else begin
          st_next.literals_left = lit_off + 7'd1;
          st_next.mode          = hdc_pkg::MODE_LIT;
        end
      end else if (in_byte inside {[hdc_pkg::RUN_BASE:hdc_pkg::RUN_LAST]}) begin
        if (end_of_stream) begin
          ctrl_res   = '{hdc_pkg::SPACE_BYTE, run_off + 7'd2, 1'b0,
                         st.error_flag, 1'b1};
          ctrl_valid = 1'b1;
        end else begin
          st_next.pending_run_length = run_off + 7'd2;
          st_next.mode               = hdc_pkg::MODE_RUN;
        end
      end else begin
        // invalid control byte: flag it and skip
        st_next.error_flag = 1'b1;
        ctrl_res   = '{8'd0, 7'd0, 1'b1, 1'b1, end_of_stream};
        ctrl_valid = 1'b1;
      end

      if (res0_valid) begin
        res1       = ctrl_res;
        res1_valid = ctrl_valid;
      end else begin
        res0       = ctrl_res;
        res0_valid = ctrl_valid;
      end
    end

    // Drop all state at the end of a stream
    if (end_of_stream) begin
      st_next = hdc_pkg::STATE_RESET;
    end
  end

endmodule

// File: rtl/hdc_run_length_decoder.sv
// Top level of the run-length decoder: state, result register, holding slot.
// Depends on hdc_pkg, hdc_decode_core and assert_macros.svh.
//
// The decoder accepts one compressed byte per cycle while it is not stalled and
// presents its result in the next cycle in the output register; bytes that only
// change state (a literal or run announcement) give no result. A byte can give
// two results only when a run announcement is followed by a control byte on the
// final byte of the stream; the second result waits in a holding slot and input
// stalls until it drains. Input also stalls while the output register is full
// and not being taken. Throughput is thus one byte per cycle when the output is
// taken, limited by the single output register, and less for two-result bytes.
`include "assert_macros.svh"

module hdc_run_length_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [6:0] repeat_count,
  output logic       bad_control,
  output logic       error_seen,
  output logic       last_out
);

  hdc_pkg::dec_state_t st;
  hdc_pkg::dec_state_t st_next;
  hdc_pkg::result_t    res0;
  hdc_pkg::result_t    res1;
  logic                res0_valid;
  logic                res1_valid;
  hdc_pkg::result_t    out_res;
  hdc_pkg::result_t    pend_res;
  logic                pend_valid;
  logic                out_free;
  logic                in_accept;

  hdc_decode_core u_core (
    .st            (st),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .st_next       (st_next),
    .res0          (res0),
    .res0_valid    (res0_valid),
    .res1          (res1),
    .res1_valid    (res1_valid)
  );

  // Handshake: take a byte when the output slot frees and nothing is held
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !pend_valid && out_free;
  assign in_accept = in_valid && in_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= hdc_pkg::STATE_RESET;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (in_accept) begin
      st         <= st_next;
      out_valid  <= res0_valid;
      pend_valid <= res1_valid;
    end else if (out_free) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  // Result payload: load new results or advance the held one
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res  <= res0;
      pend_res <= res1;
    end else if (out_free && pend_valid) begin
      out_res <= pend_res;
    end
  end

  assign out_byte     = out_res.out_byte;
  assign repeat_count = out_res.repeat_count;
  assign bad_control  = out_res.bad_control;
  assign error_seen   = out_res.error_seen;
  assign last_out     = out_res.last_out;

  // Checks on the result queue and stream boundaries
  `HDC_ASSERT_ALWAYS(a_pend_behind_out, !pend_valid || out_valid, "held result without output")
  `HDC_ASSERT_ALWAYS(a_two_only_at_end, !(in_accept && res1_valid) || end_of_stream, "two results mid-stream")
  `HDC_ASSERT_NEXT(a_end_clears, in_accept && end_of_stream, (st.mode == hdc_pkg::MODE_CTRL) && !st.error_flag, "state not cleared at stream end")

endmodule
